// File: hdl/lirt_pkg.sv
// ----------------------------------------------------------------------------
// lirt_pkg
// shared types and constants of the input record table
// ----------------------------------------------------------------------------
package lirt_pkg;

  localparam int unsigned DefaultEntries = 64;
  localparam logic [7:0]  InvalidPlayerReset = 8'd255;

  typedef enum logic [1:0] {
    MODE_STORE  = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_LATEST = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_WRITE,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the input word
    logic clr_scan; // reset scan index and scan results
    logic rd_en;    // read the entry at the scan index
    logic eval;     // fold the read entry into the scan results
    logic step;     // advance the scan index
    logic commit;   // apply the store or the clear to the entry
    logic done;     // issue the result word
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic last;     // scan index is on the final entry
    logic hit;      // store or lookup found its key, scan may stop
  } stat_t;

endpackage

// File: hdl/lirt_ctrl.sv
// ----------------------------------------------------------------------------
// lirt_ctrl
// sequencer for the entry scan: read, evaluate, write back, then report
// ----------------------------------------------------------------------------
module lirt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lirt_pkg::stat_t   stat_i,
  output lirt_pkg::ctrl_t   ctrl_o,
  output logic              busy_o
);

  lirt_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lirt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      lirt_pkg::ST_IDLE: begin
        if (start_i) begin
          ctrl_o.load     = 1'b1;
          ctrl_o.clr_scan = 1'b1;
          state_d         = lirt_pkg::ST_READ;
        end
      end
      lirt_pkg::ST_READ: begin
        ctrl_o.rd_en = 1'b1;
        state_d      = lirt_pkg::ST_EVAL;
      end
      lirt_pkg::ST_EVAL: begin
        ctrl_o.eval = 1'b1;
        state_d     = lirt_pkg::ST_WRITE;
      end
      lirt_pkg::ST_WRITE: begin
        ctrl_o.commit = 1'b1;
        if (stat_i.last || stat_i.hit) begin
          state_d = lirt_pkg::ST_DONE;
        end else begin
          ctrl_o.step = 1'b1;
          state_d     = lirt_pkg::ST_READ;
        end
      end
      lirt_pkg::ST_DONE: begin
        ctrl_o.done = 1'b1;
        state_d     = lirt_pkg::ST_IDLE;
      end
      default: state_d = lirt_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != lirt_pkg::ST_IDLE);

  // a result only follows the write-back state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.done |-> $past(state_q) == lirt_pkg::ST_WRITE)
    else $error("result without finished scan");
  // an item is only taken when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |-> !busy_o)
    else $error("load while busy");
  // read is always followed by evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.rd_en |=> ctrl_o.eval)
    else $error("read not evaluated");

endmodule

// File: hdl/lirt_dpath.sv
// ----------------------------------------------------------------------------
// lirt_dpath
// entry memories, valid bits, scan index and result registers
// ----------------------------------------------------------------------------
module lirt_dpath #(
  parameter int unsigned Entries = lirt_pkg::DefaultEntries
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lirt_pkg::ctrl_t   ctrl_i,
  output lirt_pkg::stat_t   stat_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        player_i,
  input  logic [31:0]       frame_number_i,
  input  logic [31:0]       seq_number_i,
  input  logic              is_canonical_i,
  input  logic              is_predicted_i,
  input  logic [18:0]       buttons_i,
  input  logic [15:0]       pointer_x_i,
  input  logic [15:0]       pointer_y_i,
  input  logic              count_predicted_i,
  output logic              done_o,
  output logic              inserted_o,
  output logic              replaced_guess_o,
  output logic              payload_changed_o,
  output logic              table_full_o,
  output logic              found_o,
  output logic [31:0]       found_frame_o,
  output logic [18:0]       found_buttons_o,
  output logic [15:0]       found_x_o,
  output logic [15:0]       found_y_o,
  output logic              found_canonical_o,
  output logic              found_predicted_o,
  output logic [31:0]       found_sequence_o
);

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  // entry storage: key 40, sequence 32, payload 53
  logic [39:0] key_mem [Entries];
  logic [31:0] seq_mem [Entries];
  logic [52:0] pay_mem [Entries];
  logic [Entries-1:0] valid_q;

  logic [7:0]  inv_q;
  logic [1:0]  mode_q;
  logic [39:0] key_q;
  logic [31:0] seq_q;
  logic [52:0] pay_q;
  logic        incl_q;

  logic [IdxW-1:0] idx_q;
  logic [39:0] rkey_q;
  logic [31:0] rseq_q;
  logic [52:0] rpay_q;
  logic        rval_q;

  // scan results
  logic            hit_q, free_q, any_q, take_q, guess_q;
  logic [IdxW-1:0] free_idx_q;
  logic [31:0]     best_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= lirt_pkg::InvalidPlayerReset;
    end else if (cfg_we_i) begin
      inv_q <= cfg_data_i;
    end
  end

  // input word capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mode_q <= mode_i;
      key_q  <= {player_i, frame_number_i};
      seq_q  <= seq_number_i;
      pay_q  <= {is_predicted_i, is_canonical_i, pointer_y_i, pointer_x_i, buttons_i};
      incl_q <= count_predicted_i;
    end
  end

  // registered memory read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rkey_q <= key_mem[idx_q];
      rseq_q <= seq_mem[idx_q];
      rpay_q <= pay_mem[idx_q];
      rval_q <= valid_q[idx_q];
    end
  end

  // store decision for a matching entry
  logic match, oc, op, take, guess;
  assign match = rval_q && (rkey_q == key_q);
  assign oc    = rpay_q[51];
  assign op    = rpay_q[52];
  always_comb begin
    take  = 1'b0;
    guess = 1'b0;
    priority if (oc && !pay_q[51]) begin
      take = 1'b0;
    end else if (pay_q[51]) begin
      take = 1'b1;
    end else if (op && !pay_q[52]) begin
      take  = 1'b1;
      guess = 1'b1;
    end else if (!op && pay_q[52]) begin
      take = 1'b0;
    end else begin
      take = (seq_q >= rseq_q);
    end
  end

  logic is_store, inv_store, lat_ok;
  assign is_store  = (lirt_pkg::mode_e'(mode_q) == lirt_pkg::MODE_STORE);
  assign inv_store = is_store && (key_q[39:32] == inv_q);
  assign lat_ok    = rval_q && (rkey_q[39:32] == key_q[39:32]) && (incl_q || !rpay_q[52]);

  // scan index and results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      any_q      <= 1'b0;
      take_q     <= 1'b0;
      guess_q    <= 1'b0;
      free_idx_q <= '0;
      best_q     <= '0;
    end else if (ctrl_i.clr_scan) begin
      idx_q   <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      any_q   <= 1'b0;
      take_q  <= 1'b0;
      guess_q <= 1'b0;
      best_q  <= '0;
    end else begin
      if (ctrl_i.step) begin
        idx_q <= idx_q + 1'b1;
      end
      if (ctrl_i.eval) begin
        unique case (lirt_pkg::mode_e'(mode_q))
          lirt_pkg::MODE_STORE, lirt_pkg::MODE_LOOKUP: begin
            if (match) begin
              hit_q   <= 1'b1;
              take_q  <= take;
              guess_q <= take && guess;
            end
            if (!rval_q && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= idx_q;
            end
          end
          lirt_pkg::MODE_LATEST: begin
            if (lat_ok && (!any_q || rkey_q[31:0] > best_q)) begin
              any_q  <= 1'b1;
              best_q <= rkey_q[31:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign stat_o.last = (idx_q == LastIdx);
  assign stat_o.hit  = hit_q && !(lirt_pkg::mode_e'(mode_q) == lirt_pkg::MODE_CLEAR);

  // write side: replace on hit, insert at first free slot at scan end, clear
  logic wr_en;
  logic [IdxW-1:0] wr_idx;
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = idx_q;
    if (ctrl_i.commit && is_store && !inv_store) begin
      if (hit_q) begin
        wr_en = take_q;
      end else if (stat_o.last && free_q) begin
        wr_en  = 1'b1;
        wr_idx = free_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_idx] <= key_q;
      seq_mem[wr_idx] <= seq_q;
      pay_mem[wr_idx] <= pay_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_idx] <= 1'b1;
    end else if (ctrl_i.commit && (lirt_pkg::mode_e'(mode_q) == lirt_pkg::MODE_CLEAR)
                 && rval_q && (rkey_q[31:0] < key_q[31:0])) begin
      valid_q[idx_q] <= 1'b0;
    end
  end

  // result word
  logic is_lookup, is_latest;
  assign is_lookup = (lirt_pkg::mode_e'(mode_q) == lirt_pkg::MODE_LOOKUP);
  assign is_latest = (lirt_pkg::mode_e'(mode_q) == lirt_pkg::MODE_LATEST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= ctrl_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.done) begin
      inserted_o        <= is_store && !inv_store && !hit_q && free_q;
      replaced_guess_o  <= is_store && !inv_store && hit_q && guess_q;
      payload_changed_o <= is_store && !inv_store && hit_q && take_q
                           && (rpay_q[50:0] != pay_q[50:0]);
      table_full_o      <= is_store && !inv_store && !hit_q && !free_q;
      found_o           <= (is_lookup && hit_q) || (is_latest && any_q);
      found_frame_o     <= (is_lookup && hit_q) ? key_q[31:0]
                           : ((is_latest && any_q) ? best_q : 32'd0);
      found_buttons_o   <= (is_lookup && hit_q) ? rpay_q[18:0]  : 19'd0;
      found_x_o         <= (is_lookup && hit_q) ? rpay_q[34:19] : 16'd0;
      found_y_o         <= (is_lookup && hit_q) ? rpay_q[50:35] : 16'd0;
      found_canonical_o <= is_lookup && hit_q && rpay_q[51];
      found_predicted_o <= is_lookup && hit_q && rpay_q[52];
      found_sequence_o  <= (is_lookup && hit_q) ? rseq_q : 32'd0;
    end
  end

  // a store write never lands on an entry during a clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> is_store)
    else $error("entry write outside store");
  // an insert targets a slot that was free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !hit_q) |-> !valid_q[wr_idx])
    else $error("insert over a valid entry");
  // a new entry becomes valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> valid_q[$past(wr_idx)])
    else $error("written entry not valid");

endmodule

// File: hdl/lockstep_input_record_table.sv
// ----------------------------------------------------------------------------
// lockstep_input_record_table
// table of input records keyed by player and frame, store/lookup/latest/clear
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low. Every item scans the
// table entry by entry (read, evaluate, write back) through a single
// memory port, then issues the result; a store or lookup stops early at
// its matching entry. The result word is on the outputs for one cycle with
// done_o high and cannot be held off, so it must be taken then.
module lockstep_input_record_table #(
  parameter int unsigned ENTRIES = lirt_pkg::DefaultEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_invalid_player_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  player_i,
  input  logic [31:0] frame_number_i,
  input  logic [31:0] seq_number_i,
  input  logic        is_canonical_i,
  input  logic        is_predicted_i,
  input  logic [18:0] buttons_i,
  input  logic [15:0] pointer_x_i,
  input  logic [15:0] pointer_y_i,
  input  logic        count_predicted_i,
  output logic        done_o,
  output logic        inserted_o,
  output logic        replaced_guess_o,
  output logic        payload_changed_o,
  output logic        table_full_o,
  output logic        found_o,
  output logic [31:0] found_frame_o,
  output logic [18:0] found_buttons_o,
  output logic [15:0] found_x_o,
  output logic [15:0] found_y_o,
  output logic        found_canonical_o,
  output logic        found_predicted_o,
  output logic [31:0] found_sequence_o
);

  lirt_pkg::ctrl_t ctrl;
  lirt_pkg::stat_t stat;

  // scan sequencer
  lirt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  // table and result datapath
  lirt_dpath #(.Entries(ENTRIES)) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_invalid_player_i),
    .mode_i           (mode_i),
    .player_i         (player_i),
    .frame_number_i   (frame_number_i),
    .seq_number_i     (seq_number_i),
    .is_canonical_i   (is_canonical_i),
    .is_predicted_i   (is_predicted_i),
    .buttons_i        (buttons_i),
    .pointer_x_i      (pointer_x_i),
    .pointer_y_i      (pointer_y_i),
    .count_predicted_i(count_predicted_i),
    .done_o           (done_o),
    .inserted_o       (inserted_o),
    .replaced_guess_o (replaced_guess_o),
    .payload_changed_o(payload_changed_o),
    .table_full_o     (table_full_o),
    .found_o          (found_o),
    .found_frame_o    (found_frame_o),
    .found_buttons_o  (found_buttons_o),
    .found_x_o        (found_x_o),
    .found_y_o        (found_y_o),
    .found_canonical_o(found_canonical_o),
    .found_predicted_o(found_predicted_o),
    .found_sequence_o (found_sequence_o)
  );

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the lockstep input record table: a shadow table
// predicts each result word, directed tasks cover the store priority rules,
// full table, latest, clear and the invalid player, then random traffic runs
// over several invalid player settings, with random gaps on the start side
// in all runs but one
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = int'(lirt_pkg::DefaultEntries);

  localparam lirt_pkg::mode_e ModeStore  = lirt_pkg::MODE_STORE;
  localparam lirt_pkg::mode_e ModeLookup = lirt_pkg::MODE_LOOKUP;
  localparam lirt_pkg::mode_e ModeLatest = lirt_pkg::MODE_LATEST;
  localparam lirt_pkg::mode_e ModeClear  = lirt_pkg::MODE_CLEAR;

  typedef struct {
    lirt_pkg::mode_e mode;
    logic [7:0]  player;
    logic [31:0] frame;
    logic [31:0] seq;
    logic        canon;
    logic        pred;
    logic [18:0] buttons;
    logic [15:0] px;
    logic [15:0] py;
    logic        count_pred;
  } word_t;

  typedef struct {
    logic        inserted;
    logic        replaced_guess;
    logic        payload_changed;
    logic        table_full;
    logic        found;
    logic [31:0] found_frame;
    logic [18:0] found_buttons;
    logic [15:0] found_x;
    logic [15:0] found_y;
    logic        found_canonical;
    logic        found_predicted;
    logic [31:0] found_sequence;
  } reply_t;

  typedef struct {
    logic        valid;
    logic [7:0]  player;
    logic [31:0] frame;
    logic [31:0] seq;
    logic        canon;
    logic        pred;
    logic [18:0] buttons;
    logic [15:0] px;
    logic [15:0] py;
  } record_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_invalid_player_i;
  logic        start;
  logic        busy;
  logic [1:0]  mode_i;
  logic [7:0]  player_i;
  logic [31:0] frame_number_i;
  logic [31:0] seq_number_i;
  logic        is_canonical_i;
  logic        is_predicted_i;
  logic [18:0] buttons_i;
  logic [15:0] pointer_x_i;
  logic [15:0] pointer_y_i;
  logic        count_predicted_i;
  logic        done_o;
  logic        inserted_o;
  logic        replaced_guess_o;
  logic        payload_changed_o;
  logic        table_full_o;
  logic        found_o;
  logic [31:0] found_frame_o;
  logic [18:0] found_buttons_o;
  logic [15:0] found_x_o;
  logic [15:0] found_y_o;
  logic        found_canonical_o;
  logic        found_predicted_o;
  logic [31:0] found_sequence_o;

  record_t     shadow_table [Slots];
  logic [7:0]  shadow_invalid;
  reply_t      pending_replies [$];
  int          errors;
  bit          no_idle;

  lockstep_input_record_table u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_invalid_player_i (cfg_invalid_player_i),
    .start                (start),
    .busy                 (busy),
    .mode_i               (mode_i),
    .player_i             (player_i),
    .frame_number_i       (frame_number_i),
    .seq_number_i         (seq_number_i),
    .is_canonical_i       (is_canonical_i),
    .is_predicted_i       (is_predicted_i),
    .buttons_i            (buttons_i),
    .pointer_x_i          (pointer_x_i),
    .pointer_y_i          (pointer_y_i),
    .count_predicted_i    (count_predicted_i),
    .done_o               (done_o),
    .inserted_o           (inserted_o),
    .replaced_guess_o     (replaced_guess_o),
    .payload_changed_o    (payload_changed_o),
    .table_full_o         (table_full_o),
    .found_o              (found_o),
    .found_frame_o        (found_frame_o),
    .found_buttons_o      (found_buttons_o),
    .found_x_o            (found_x_o),
    .found_y_o            (found_y_o),
    .found_canonical_o    (found_canonical_o),
    .found_predicted_o    (found_predicted_o),
    .found_sequence_o     (found_sequence_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // shadow of the record table, one word in, one reply out
  function automatic reply_t table_step(word_t w);
    reply_t  r;
    int      hit;
    bit      take;
    bit      any;
    record_t old;
    r   = '{default: '0};
    hit = -1;
    for (int i = 0; i < Slots; i++)
      if (hit < 0 && shadow_table[i].valid && shadow_table[i].player == w.player &&
          shadow_table[i].frame == w.frame)
        hit = i;
    case (w.mode)
      ModeStore: begin
        if (w.player == shadow_invalid) return r;
        if (hit >= 0) begin
          old = shadow_table[hit];
          if (old.canon && !w.canon) take = 0;
          else if (w.canon) take = 1;
          else if (old.pred && !w.pred) begin
            take = 1;
            r.replaced_guess = 1;
          end else if (!old.pred && w.pred) take = 0;
          else take = (w.seq >= old.seq);
          if (take) begin
            r.payload_changed = (old.buttons != w.buttons) || (old.px != w.px) ||
                                (old.py != w.py);
            shadow_table[hit] = '{1'b1, w.player, w.frame, w.seq, w.canon, w.pred,
                                  w.buttons, w.px, w.py};
          end
          return r;
        end
        for (int i = 0; i < Slots; i++)
          if (!shadow_table[i].valid) begin
            shadow_table[i] = '{1'b1, w.player, w.frame, w.seq, w.canon, w.pred,
                                w.buttons, w.px, w.py};
            r.inserted = 1;
            return r;
          end
        r.table_full = 1;
      end
      ModeLookup: begin
        if (hit >= 0) begin
          r.found           = 1;
          r.found_frame     = shadow_table[hit].frame;
          r.found_buttons   = shadow_table[hit].buttons;
          r.found_x         = shadow_table[hit].px;
          r.found_y         = shadow_table[hit].py;
          r.found_canonical = shadow_table[hit].canon;
          r.found_predicted = shadow_table[hit].pred;
          r.found_sequence  = shadow_table[hit].seq;
        end
      end
      ModeLatest: begin
        any = 0;
        for (int i = 0; i < Slots; i++) begin
          if (!shadow_table[i].valid || shadow_table[i].player != w.player) continue;
          if (!w.count_pred && shadow_table[i].pred) continue;
          if (!any || shadow_table[i].frame > r.found_frame) begin
            r.found_frame = shadow_table[i].frame;
            any = 1;
          end
        end
        r.found = any;
      end
      default: begin
        for (int i = 0; i < Slots; i++)
          if (shadow_table[i].valid && shadow_table[i].frame < w.frame)
            shadow_table[i].valid = 0;
      end
    endcase
    return r;
  endfunction

  function automatic word_t mk(lirt_pkg::mode_e m, logic [7:0] p, logic [31:0] f,
                               logic [31:0] s, logic c, logic pr, logic [18:0] b,
                               logic [15:0] x, logic [15:0] y, logic cp);
    word_t w;
    w = '{m, p, f, s, c, pr, b, x, y, cp};
    return w;
  endfunction

  // random word, mostly a small key space so keys collide
  function automatic word_t rand_word();
    word_t w;
    int    m;
    m = $urandom_range(99);
    w.mode = (m < 55) ? ModeStore : (m < 75) ? ModeLookup :
             (m < 92) ? ModeLatest : ModeClear;
    w.player  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    w.frame   = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(40));
    if (w.mode == ModeClear && $urandom_range(3) != 0) w.frame = $urandom_range(12);
    w.seq     = ($urandom_range(1) == 0) ? $urandom : 32'($urandom_range(7));
    w.canon   = ($urandom_range(3) == 0);
    w.pred    = 1'($urandom_range(1));
    w.buttons = ($urandom_range(1) == 0) ? 19'($urandom) : 19'($urandom_range(1));
    w.px      = 16'($urandom);
    w.py      = 16'($urandom);
    w.count_pred = 1'($urandom_range(1));
    return w;
  endfunction

  // queue a predicted reply behind the ones still owed
  function automatic void enqueue_reply(reply_t r);
    pending_replies.insert(pending_replies.size(), r);
  endfunction

  // present one word and wait for it to be taken
  task automatic send_word(word_t w);
    start             <= 1'b1;
    mode_i            <= w.mode;
    player_i          <= w.player;
    frame_number_i    <= w.frame;
    seq_number_i      <= w.seq;
    is_canonical_i    <= w.canon;
    is_predicted_i    <= w.pred;
    buttons_i         <= w.buttons;
    pointer_x_i       <= w.px;
    pointer_y_i       <= w.py;
    count_predicted_i <= w.count_pred;
    do @(posedge clk_i); while (busy);
    enqueue_reply(table_step(w));
    if (!no_idle && $urandom_range(99) < 26) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // wait until every reply is in
  task automatic drain();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_invalid_player(logic [7:0] v);
    drain();
    cfg_we_i             <= 1'b1;
    cfg_invalid_player_i <= v;
    @(posedge clk_i);
    shadow_invalid = v;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t mismatch %s expected %h actual %h", $realtime, name, e, a);
    end
  endtask

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    reply_t e;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t unexpected result word", $realtime);
      end else begin
        e = pending_replies.pop_front();
        check_field("inserted", 32'(e.inserted), 32'(inserted_o));
        check_field("replaced_guess", 32'(e.replaced_guess), 32'(replaced_guess_o));
        check_field("payload_changed", 32'(e.payload_changed), 32'(payload_changed_o));
        check_field("table_full", 32'(e.table_full), 32'(table_full_o));
        check_field("found", 32'(e.found), 32'(found_o));
        check_field("found_frame", e.found_frame, found_frame_o);
        check_field("found_buttons", 32'(e.found_buttons), 32'(found_buttons_o));
        check_field("found_x", 32'(e.found_x), 32'(found_x_o));
        check_field("found_y", 32'(e.found_y), 32'(found_y_o));
        check_field("found_canonical", 32'(e.found_canonical), 32'(found_canonical_o));
        check_field("found_predicted", 32'(e.found_predicted), 32'(found_predicted_o));
        check_field("found_sequence", e.found_sequence, found_sequence_o);
      end
    end
  end

  // priority rules on an existing key
  task automatic test_store_rules();
    send_word(mk(ModeStore, 8'd0, 32'd0, 32'd5, 0, 1, 19'h7FFFF, 16'hFFFF, 16'hFFFF, 0));
    send_word(mk(ModeStore, 8'd0, 32'd0, 32'd4, 0, 1, 19'h1, 16'h1, 16'h1, 0));
    send_word(mk(ModeStore, 8'd0, 32'd0, 32'd5, 0, 1, 19'h2, 16'h1, 16'h1, 0));
    send_word(mk(ModeStore, 8'd0, 32'd0, 32'd0, 0, 0, 19'h2, 16'h1, 16'h1, 0));
    send_word(mk(ModeStore, 8'd0, 32'd0, 32'hFFFFFFFF, 0, 1, 19'h3, 16'h0, 16'h0, 0));
    send_word(mk(ModeStore, 8'd0, 32'd0, 32'd1, 1, 0, 19'h0, 16'h0, 16'h0, 0));
    send_word(mk(ModeStore, 8'd0, 32'd0, 32'hFFFFFFFF, 0, 0, 19'h5, 16'h0, 16'h0, 0));
    send_word(mk(ModeStore, 8'd0, 32'd0, 32'd0, 1, 1, 19'h5, 16'h0, 16'h0, 0));
    send_word(mk(ModeLookup, 8'd0, 32'd0, 32'd0, 0, 0, 19'h0, 16'h0, 16'h0, 0));
    send_word(mk(ModeLookup, 8'd0, 32'd1, 32'd0, 1, 1, 19'h7FFFF, 16'hFFFF, 16'hFFFF, 1));
    send_word(mk(ModeStore, 8'd254, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1, 19'h7FFFF,
                 16'hFFFF, 16'hFFFF, 1));
    send_word(mk(ModeLookup, 8'd254, 32'hFFFFFFFF, 32'd0, 0, 0, 19'h0, 16'h0, 16'h0, 0));
  endtask

  // store from the invalid player leaves everything alone
  task automatic test_invalid_player();
    send_word(mk(ModeStore, 8'd255, 32'd7, 32'd1, 0, 0, 19'h1, 16'h1, 16'h1, 0));
    send_word(mk(ModeLookup, 8'd255, 32'd7, 32'd0, 0, 0, 19'h0, 16'h0, 16'h0, 0));
    write_invalid_player(8'd0);
    send_word(mk(ModeStore, 8'd0, 32'd9, 32'd1, 0, 0, 19'h1, 16'h1, 16'h1, 0));
    send_word(mk(ModeStore, 8'd255, 32'd7, 32'd1, 0, 0, 19'h1, 16'h1, 16'h1, 0));
    send_word(mk(ModeLookup, 8'd255, 32'd7, 32'd0, 0, 0, 19'h0, 16'h0, 16'h0, 0));
  endtask

  // latest frame with and without predicted records
  task automatic test_latest();
    send_word(mk(ModeStore, 8'd2, 32'd10, 32'd0, 0, 0, 19'h0, 16'h0, 16'h0, 0));
    send_word(mk(ModeStore, 8'd2, 32'd20, 32'd0, 0, 1, 19'h0, 16'h0, 16'h0, 0));
    send_word(mk(ModeLatest, 8'd2, 32'd0, 32'd0, 0, 0, 19'h0, 16'h0, 16'h0, 0));
    send_word(mk(ModeLatest, 8'd2, 32'd0, 32'd0, 0, 0, 19'h0, 16'h0, 16'h0, 1));
    send_word(mk(ModeLatest, 8'd9, 32'd0, 32'd0, 0, 0, 19'h0, 16'h0, 16'h0, 1));
  endtask

  // clear then fill past capacity
  task automatic test_clear_and_full();
    send_word(mk(ModeClear, 8'd0, 32'd15, 32'd0, 0, 0, 19'h0, 16'h0, 16'h0, 0));
    send_word(mk(ModeLatest, 8'd2, 32'd0, 32'd0, 0, 0, 19'h0, 16'h0, 16'h0, 1));
    send_word(mk(ModeClear, 8'd0, 32'hFFFFFFFF, 32'd0, 0, 0, 19'h0, 16'h0, 16'h0, 0));
    for (int i = 0; i < Slots + 3; i++)
      send_word(mk(ModeStore, 8'd1, 32'(i), 32'(i), 0, 0, 19'(i), 16'(i), 16'(i), 0));
    send_word(mk(ModeLookup, 8'd1, 32'd40, 32'd0, 0, 0, 19'h0, 16'h0, 16'h0, 0));
    send_word(mk(ModeClear, 8'd0, 32'd0, 32'd0, 0, 0, 19'h0, 16'h0, 16'h0, 0));
    send_word(mk(ModeClear, 8'd0, 32'd50, 32'd0, 0, 0, 19'h0, 16'h0, 16'h0, 0));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_word(rand_word());
  endtask

  // run the tests in turn
  initial begin
    int guard;
    errors = 0;
    no_idle = 0;
    for (int i = 0; i < Slots; i++) shadow_table[i] = '{default: '0};
    shadow_invalid = lirt_pkg::InvalidPlayerReset;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_invalid_player_i <= 8'd0;
    start                <= 1'b0;
    mode_i               <= '0;
    player_i             <= '0;
    frame_number_i       <= '0;
    seq_number_i         <= '0;
    is_canonical_i       <= 1'b0;
    is_predicted_i       <= 1'b0;
    buttons_i            <= '0;
    pointer_x_i          <= '0;
    pointer_y_i          <= '0;
    count_predicted_i    <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_store_rules();
    test_latest();
    test_clear_and_full();
    test_invalid_player();

    write_invalid_player(8'd255);
    test_random(200);
    write_invalid_player(8'd3);
    no_idle = 1;
    test_random(200);
    no_idle = 0;
    drain();
    write_invalid_player(8'($urandom));
    test_random(200);
    write_invalid_player(8'd1);
    test_random(200);

    start <= 1'b0;
    guard = 0;
    while (pending_replies.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_replies.size() != 0) begin
      errors++;
      $display("%0t %0d result words never arrived", $realtime, pending_replies.size());
    end
    repeat (400) @(posedge clk_i);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
hdl/lirt_pkg.sv
hdl/lirt_ctrl.sv
hdl/lirt_dpath.sv
hdl/lockstep_input_record_table.sv
sim/tb.sv
